// ===== sv/swfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_pkg
// Shared types, constants and helpers for the sliding window flow sender.
// ----------------------------------------------------------------------------
package swfs_pkg;

    // Default sizes of the flow table and the initial peer window.
    localparam int FLOW_DEPTH_DEF     = 128;
    localparam int INITIAL_WINDOW_DEF = 64;

    // Width used to compare a flow index against the table depth.
    localparam int IDX_EXT_W = 11;

    // Field widths.
    localparam int FLOW_IDX_W = 7;
    localparam int SEQ_W      = 16;
    localparam int SEQX_W     = 17;
    localparam int FCNT_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 1'b1;

    // Register reset values.
    localparam logic [FCNT_W-1:0] FLOW_COUNT_RST    = 8'd1;
    localparam logic [SEQ_W-1:0]  TOTAL_PACKETS_RST = 16'd10;

    // Item function codes.
    localparam logic FUNC_SEND = 1'b0;
    localparam logic FUNC_ACK  = 1'b1;

    // Per-flow state held in one table entry.
    typedef struct packed {
        logic [SEQX_W-1:0] next_seq;
        logic [SEQ_W-1:0]  last_ack;
        logic [SEQ_W-1:0]  written_count;
        logic [SEQX_W-1:0] inflight_count;
        logic [SEQ_W-1:0]  acked_total;
        logic [SEQ_W-1:0]  peer_window;
        logic [SEQ_W-1:0]  effective_win;
        logic              done_flag;
    } entry_t;

    // Item fields that the update logic needs.
    typedef struct packed {
        logic             func;
        logic [SEQ_W-1:0] ack_seq;
        logic [SEQ_W-1:0] adv_window;
        logic             reject;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [SEQ_W-1:0] first_seq;
        logic [SEQ_W-1:0] send_count;
        logic [SEQ_W-1:0] eff_window;
        logic             flow_done;
        logic             status;
    } result_t;

    // Entry value that a flow holds after reset.
    function automatic entry_t reset_entry(input logic [SEQ_W-1:0] init_win);
        entry_t e;
        e.next_seq       = 17'd1;
        e.last_ack       = '0;
        e.written_count  = '0;
        e.inflight_count = '0;
        e.acked_total    = '0;
        e.peer_window    = init_win;
        e.effective_win  = init_win;
        e.done_flag      = 1'b0;
        return e;
    endfunction

endpackage

// ===== sv/swfs_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfs_update
// Read-modify-write datapath: takes one flow entry and one item, and gives
// the new entry and the result item.
// ----------------------------------------------------------------------------
module swfs_update
(
    input  swfs_pkg::item_t              item,
    input  swfs_pkg::entry_t             old_entry,
    input  logic [swfs_pkg::SEQ_W-1:0]   total_packets,
    output swfs_pkg::entry_t             new_entry,
    output swfs_pkg::result_t            result
);

    // Send path signals.
    logic [swfs_pkg::SEQX_W-1:0] flying;
    logic [swfs_pkg::SEQ_W-1:0]  avail;
    logic [swfs_pkg::SEQ_W-1:0]  remain;
    logic [swfs_pkg::SEQ_W-1:0]  count;
    logic [swfs_pkg::SEQX_W-1:0] flying_diff;

    // Ack path signals.
    logic                        ack_newer;
    logic [swfs_pkg::SEQ_W-1:0]  fresh;
    logic [swfs_pkg::SEQX_W-1:0] acked_sum;
    logic [swfs_pkg::SEQ_W-1:0]  acked_new;
    logic [swfs_pkg::SEQX_W-1:0] inflight_new;
    logic [swfs_pkg::SEQ_W-1:0]  eff_new;
    logic [swfs_pkg::SEQ_W-1:0]  acked_after;

    // Window available for sending and packets still to be written.
    always_comb
    begin
        flying      = old_entry.next_seq - {1'b0, old_entry.last_ack} - 17'd1;
        flying_diff = {1'b0, old_entry.peer_window} - flying;
        avail       = '0;
        if ((old_entry.next_seq > {1'b0, old_entry.last_ack}) &&
            ({1'b0, old_entry.peer_window} > flying))
        begin
            avail = flying_diff[swfs_pkg::SEQ_W-1:0];
        end
        remain = '0;
        if (total_packets > old_entry.written_count)
        begin
            remain = total_packets - old_entry.written_count;
        end
        count = (avail < remain) ? avail : remain;
    end

    // Cumulative acknowledgement arithmetic.
    always_comb
    begin
        ack_newer = item.ack_seq > old_entry.last_ack;
        fresh     = item.ack_seq - old_entry.last_ack;
        acked_sum = {1'b0, old_entry.acked_total} + {1'b0, fresh};
        acked_new = acked_sum[swfs_pkg::SEQ_W] ? '1 : acked_sum[swfs_pkg::SEQ_W-1:0];
        if (old_entry.inflight_count > {1'b0, fresh})
        begin
            inflight_new = old_entry.inflight_count - {1'b0, fresh};
        end
        else
        begin
            inflight_new = '0;
        end
        if ({1'b0, item.adv_window} > inflight_new)
        begin
            eff_new = item.adv_window - inflight_new[swfs_pkg::SEQ_W-1:0];
        end
        else
        begin
            eff_new = '0;
        end
        acked_after = ack_newer ? acked_new : old_entry.acked_total;
    end

    // New entry and result item.
    always_comb
    begin
        new_entry = old_entry;
        result    = '0;
        if (item.reject)
        begin
            result.status = 1'b1;
        end
        else if (item.func == swfs_pkg::FUNC_SEND)
        begin
            result.first_seq = old_entry.next_seq[swfs_pkg::SEQ_W-1:0];
            if (!old_entry.done_flag)
            begin
                result.send_count        = count;
                new_entry.next_seq       = old_entry.next_seq + {1'b0, count};
                new_entry.written_count  = old_entry.written_count + count;
                new_entry.inflight_count = old_entry.inflight_count + {1'b0, count};
            end
            result.eff_window = old_entry.effective_win;
            result.flow_done  = old_entry.done_flag;
        end
        else
        begin
            new_entry.peer_window = item.adv_window;
            if (ack_newer)
            begin
                new_entry.acked_total    = acked_new;
                new_entry.inflight_count = inflight_new;
                new_entry.last_ack       = item.ack_seq;
                new_entry.effective_win  = eff_new;
            end
            new_entry.done_flag = old_entry.done_flag || (acked_after >= total_packets);
            result.eff_window   = new_entry.effective_win;
            result.flow_done    = new_entry.done_flag;
        end
    end

endmodule

// ===== sv/sliding_window_flow_sender_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_flow_sender_core
// Per-flow sliding window sender state table with cumulative acknowledgements.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries send opportunities and acks,
// each naming one flow. The output channel (out_valid/out_ready) returns one
// result per transfer: first sequence number, send count, effective window,
// done flag and status. Configuration (flow_count, total_packets) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce. The flow state sits
// in one table memory with a registered read. An item reads its entry into
// the read data register at the input transfer; in the execute state, once the
// output register is free or being taken, the update is written back and the
// result is loaded into the output register. The block takes no new item
// until the result of the current item has been loaded.
// After reset a clearing pass writes the reset value into every entry, one
// entry per cycle; in_ready stays low during it.
// When the receiver stalls, a finished result waits in the output register;
// one more item may be accepted and read, and it then waits for the output
// register to empty before it writes back.
// ----------------------------------------------------------------------------
module sliding_window_flow_sender_core
#(
    parameter int FLOW_DEPTH     = swfs_pkg::FLOW_DEPTH_DEF,
    parameter int INITIAL_WINDOW = swfs_pkg::INITIAL_WINDOW_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [swfs_pkg::FLOW_IDX_W-1:0]   flow_index,
    input  logic [swfs_pkg::SEQ_W-1:0]        ack_seq,
    input  logic [swfs_pkg::SEQ_W-1:0]        adv_window,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [swfs_pkg::SEQ_W-1:0]        first_seq,
    output logic [swfs_pkg::SEQ_W-1:0]        send_count,
    output logic [swfs_pkg::SEQ_W-1:0]        eff_window,
    output logic                              flow_done,
    output logic                              status,
    // Configuration port.
    input  logic                              cfg_we,
    input  logic [swfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swfs_pkg::CFG_W-1:0]        cfg_data
);

    localparam int AW = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(FLOW_DEPTH - 1);
    localparam logic [swfs_pkg::IDX_EXT_W-1:0] DEPTH_EXT =
        swfs_pkg::IDX_EXT_W'(FLOW_DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Control and item registers.
    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    swfs_pkg::item_t                 item_reg, item_next;
    logic                            out_valid_reg, out_valid_next;
    swfs_pkg::result_t               result_reg, result_next;
    logic [swfs_pkg::FCNT_W-1:0]     flow_count_reg;
    logic [swfs_pkg::SEQ_W-1:0]      total_packets_reg;

    // Table memory and its read data.
    swfs_pkg::entry_t                mem [FLOW_DEPTH];
    swfs_pkg::entry_t                rd_data_reg;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    swfs_pkg::entry_t                wr_data;

    logic [swfs_pkg::IDX_EXT_W-1:0]  idx_ext;
    logic                            in_xfer;
    logic                            load;
    swfs_pkg::entry_t                new_entry;
    swfs_pkg::result_t               upd_result;

    assign idx_ext  = swfs_pkg::IDX_EXT_W'(flow_index);
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign load     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_count_reg    <= swfs_pkg::FLOW_COUNT_RST;
            total_packets_reg <= swfs_pkg::TOTAL_PACKETS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swfs_pkg::REG_FLOW_COUNT:
                    flow_count_reg <= cfg_data[swfs_pkg::FCNT_W-1:0];
                swfs_pkg::REG_TOTAL_PACKETS:
                    total_packets_reg <= cfg_data[swfs_pkg::SEQ_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Entry update datapath.
    swfs_update u_update
    (
        .item          (item_reg),
        .old_entry     (rd_data_reg),
        .total_packets (total_packets_reg),
        .new_entry     (new_entry),
        .result        (upd_result)
    );

    // Memory write port: clearing pass or item write-back.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = new_entry;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = swfs_pkg::reset_entry(swfs_pkg::SEQ_W'(INITIAL_WINDOW));
        end
        else if (load && !item_reg.reject)
        begin
            wr_en = 1'b1;
        end
    end

    // Table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (in_xfer)
        begin
            rd_data_reg <= mem[idx_ext[AW-1:0]];
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        addr_next      = addr_reg;
        item_next      = item_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    addr_next             = idx_ext[AW-1:0];
                    item_next.func        = func;
                    item_next.ack_seq     = ack_seq;
                    item_next.adv_window  = adv_window;
                    item_next.reject      = ({1'b0, flow_index} >= flow_count_reg) ||
                                            (idx_ext >= DEPTH_EXT);
                    state_next            = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (load)
                begin
                    result_next    = upd_result;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign first_seq  = result_reg.first_seq;
    assign send_count = result_reg.send_count;
    assign eff_window = result_reg.eff_window;
    assign flow_done  = result_reg.flow_done;
    assign status     = result_reg.status;

endmodule
